// ----- hw/rtl/cffa_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffa_pkg
// Shared widths, codes and types of the contiguous first-fit allocator.
// ----------------------------------------------------------------------------
package cffa_pkg;

    // payload and register widths
    localparam int SIZE_W    = 20;          // file_size_kb
    localparam int BS_W      = 11;          // block_size_kb register
    localparam int BIU_W     = 7;           // blocks_in_use register
    localparam int NEED_W    = SIZE_W + 1;  // rounded-up block count
    localparam int FIRST_W   = 6;           // first_block
    localparam int COUNT_W   = 7;           // blocks_used
    localparam int NUM_W     = 16;          // file_number
    localparam int DIV_CNT_W = $clog2(SIZE_W);

    localparam int DEF_MAX_BLOCKS = 64;

    // APB register file
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_BLOCK_SIZE    = 1'b0;  // byte address 0
    localparam logic REG_BLOCKS_IN_USE = 1'b1;  // byte address 4

    localparam logic [BS_W-1:0]  BS_RESET  = 11'd1;
    localparam logic [BIU_W-1:0] BIU_RESET = 7'd64;

    // command codes
    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef enum logic [2:0] {
        ST_CLR,
        ST_IDLE,
        ST_DIV,
        ST_SCAN,
        ST_MARK,
        ST_RESP
    } eng_state_t;

    typedef struct packed {
        logic start;
        logic clear;
    } eng_req_t;

    typedef struct packed {
        logic idle;
        logic done;
        logic ok;
    } eng_stat_t;

endpackage

// ----- hw/rtl/cffa_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffa_ram
// Generic simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module cffa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/cffa_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffa_div
// Restoring radix-2 divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module cffa_div
    import cffa_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SIZE_W-1:0] dividend,
    input  logic [BS_W-1:0]   divisor,
    output logic              done,
    output logic [SIZE_W-1:0] quotient,
    output logic [BS_W-1:0]   remainder
);

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(SIZE_W - 1);

    logic                 busy_reg;
    logic                 done_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic [SIZE_W-1:0]    quo_reg, quo_next;
    logic [BS_W-1:0]      rem_reg, rem_next;
    logic [BS_W-1:0]      dsr_reg;
    logic [BS_W:0]        trial;
    logic [BS_W:0]        diff;

    always_comb
    begin
        trial = {rem_reg, quo_reg[SIZE_W-1]};
        diff  = trial - {1'b0, dsr_reg};
        if (trial >= {1'b0, dsr_reg})
        begin
            rem_next = diff[BS_W-1:0];
            quo_next = {quo_reg[SIZE_W-2:0], 1'b1};
        end
        else
        begin
            rem_next = trial[BS_W-1:0];
            quo_next = {quo_reg[SIZE_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == LAST_STEP)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ----- hw/rtl/cffa_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffa_engine
// Block map sequencer: divide, first-fit scan, run marking and clear sweep.
// ----------------------------------------------------------------------------
module cffa_engine
    import cffa_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  eng_req_t                         req,
    input  logic [SIZE_W-1:0]                size,
    input  logic [BS_W-1:0]                  blk_size,
    input  logic [$clog2(MAX_BLOCKS+1)-1:0]  limit,
    input  logic                             rsp_take,
    output eng_stat_t                        stat,
    output logic [FIRST_W-1:0]               first,
    output logic [COUNT_W-1:0]               count
);

    localparam int IDX_W = $clog2(MAX_BLOCKS);
    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_BLOCKS - 1);

    eng_state_t state_reg, state_next;

    logic [IDX_W-1:0] clr_idx_reg;
    logic             reply_reg;
    logic             pend_reg;
    logic             clr_cmd_reg;
    logic             alloc_ok_reg;
    logic [CNT_W-1:0] limit_reg;
    logic [CNT_W-1:0] need_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic [IDX_W-1:0] ev_idx_reg;
    logic [CNT_W-1:0] run_reg;
    logic [IDX_W-1:0] mark_idx_reg;
    logic [IDX_W-1:0] end_idx_reg;
    logic [IDX_W-1:0] start_idx_reg;

    // map RAM port
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic [0:0]       wr_data;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic [0:0]       rd_data;

    // divider
    logic              div_start;
    logic              div_done;
    logic [SIZE_W-1:0] quotient;
    logic [BS_W-1:0]   remainder;

    logic [NEED_W-1:0] need_full;
    logic              need_fits;
    logic              issue;
    logic              used;
    logic [CNT_W-1:0]  run_inc;
    logic              hit;
    logic              miss;
    logic [CNT_W-1:0]  start_full;
    logic              clr_last;
    logic              mark_last;

    cffa_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (size),
        .divisor   (blk_size),
        .done      (div_done),
        .quotient  (quotient),
        .remainder (remainder)
    );

    cffa_ram #(
        .WIDTH (1),
        .DEPTH (MAX_BLOCKS)
    ) u_map (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // ceil(size / block size)
    always_comb
    begin
        need_full = {1'b0, quotient} + NEED_W'(remainder != '0);
        need_fits = (need_full != '0) && (need_full <= NEED_W'(limit_reg));
    end

    // scan datapath: ev_idx_reg is the block whose bit shows on rd_data
    always_comb
    begin
        issue      = rd_idx_reg < limit_reg;
        used       = rd_data[0];
        run_inc    = run_reg + 1'b1;
        hit        = pend_reg && !used && (run_inc == need_reg);
        miss       = !hit && !issue;
        start_full = CNT_W'(ev_idx_reg) + 1'b1 - need_reg;
        clr_last   = clr_idx_reg == LAST_IDX;
        mark_last  = mark_idx_reg == end_idx_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLR:
            begin
                if (clr_last)
                begin
                    state_next = reply_reg ? ST_RESP : ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.start)
                begin
                    state_next = req.clear ? ST_CLR : ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = need_fits ? ST_SCAN : ST_RESP;
                end
            end
            ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = ST_MARK;
                end
                else if (miss)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_MARK:
            begin
                if (mark_last)
                begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (rsp_take)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        wr_en     = 1'b0;
        wr_addr   = clr_idx_reg;
        wr_data   = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = rd_idx_reg[IDX_W-1:0];
        div_start = 1'b0;
        stat      = '0;
        case (state_reg)
            ST_CLR:
            begin
                wr_en = 1'b1;
            end
            ST_IDLE:
            begin
                stat.idle = 1'b1;
                div_start = req.start && !req.clear;
            end
            ST_DIV:
            begin
                div_start = 1'b0;
            end
            ST_SCAN:
            begin
                rd_en = issue;
            end
            ST_MARK:
            begin
                wr_en   = 1'b1;
                wr_addr = mark_idx_reg;
                wr_data = 1'b1;
            end
            ST_RESP:
            begin
                stat.done = rsp_take;
                stat.ok   = clr_cmd_reg || alloc_ok_reg;
            end
            default:
            begin
                stat = '0;
            end
        endcase
    end

    assign first = alloc_ok_reg ? FIRST_W'(start_idx_reg) : '0;
    assign count = alloc_ok_reg ? COUNT_W'(need_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLR;
            clr_idx_reg <= '0;
            reply_reg   <= 1'b0;
            pend_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                ST_CLR:
                begin
                    clr_idx_reg <= clr_idx_reg + 1'b1;
                end
                ST_IDLE:
                begin
                    if (req.start)
                    begin
                        reply_reg   <= 1'b1;
                        clr_idx_reg <= '0;
                    end
                end
                ST_DIV:
                begin
                    pend_reg <= 1'b0;
                end
                ST_SCAN:
                begin
                    pend_reg <= issue && !hit;
                end
                default:
                begin
                    pend_reg <= 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (req.start)
                begin
                    clr_cmd_reg  <= req.clear;
                    alloc_ok_reg <= 1'b0;
                    limit_reg    <= limit;
                end
            end
            ST_DIV:
            begin
                need_reg   <= CNT_W'(need_full);
                rd_idx_reg <= '0;
                run_reg    <= '0;
            end
            ST_SCAN:
            begin
                if (issue)
                begin
                    rd_idx_reg <= rd_idx_reg + 1'b1;
                end
                ev_idx_reg <= rd_idx_reg[IDX_W-1:0];
                if (pend_reg)
                begin
                    run_reg <= used ? '0 : run_inc;
                end
                if (hit)
                begin
                    end_idx_reg   <= ev_idx_reg;
                    start_idx_reg <= start_full[IDX_W-1:0];
                    mark_idx_reg  <= start_full[IDX_W-1:0];
                end
            end
            ST_MARK:
            begin
                mark_idx_reg <= mark_idx_reg + 1'b1;
                if (mark_last)
                begin
                    alloc_ok_reg <= 1'b1;
                end
            end
            default:
            begin
                alloc_ok_reg <= alloc_ok_reg;
            end
        endcase
    end

endmodule

// ----- hw/rtl/contiguous_first_fit_allocator_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// contiguous_first_fit_allocator_top
// Contiguous first-fit block allocator with APB configuration.
// ----------------------------------------------------------------------------
// Each input beat is an allocate (cmd 0) or a free-all (cmd 1) and yields
// exactly one output beat. An allocate rounds file_size_kb up to whole blocks
// with a 20-step serial divider, then walks the used-block map from block 0
// one block per cycle (the map RAM's single read port sets the pace) until
// the first free run of that length shows up, then marks the run one block
// per cycle through the write port. An allocate scans at most blocks_in_use
// blocks (clamped to MAX_BLOCKS); a free-all runs the zeroing sweep over all
// MAX_BLOCKS map entries. Right after reset the same sweep runs with in_stall
// high; APB writes are taken throughout. One request is in flight at a time;
// the output register lets the next request start while the previous result
// waits on out_stall.
// ----------------------------------------------------------------------------
module contiguous_first_fit_allocator_top
    import cffa_pkg::*;
#(
    parameter int MAX_BLOCKS = DEF_MAX_BLOCKS
) (
    input  logic                clk,
    input  logic                rst_n,

    // APB configuration port
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,

    // request channel
    input  logic                in_valid,
    output logic                in_stall,
    input  logic                cmd,
    input  logic [SIZE_W-1:0]   file_size_kb,

    // result channel
    output logic                out_valid,
    input  logic                out_stall,
    output logic                ok,
    output logic [FIRST_W-1:0]  first_block,
    output logic [COUNT_W-1:0]  blocks_used,
    output logic [NUM_W-1:0]    file_number
);

    localparam int CNT_W = $clog2(MAX_BLOCKS + 1);

    // configuration registers
    logic [BS_W-1:0]  bs_reg;
    logic [BIU_W-1:0] biu_reg;
    logic             cfg_wr;

    // request bookkeeping
    logic [NUM_W-1:0] req_cnt_reg;
    logic [NUM_W-1:0] num_reg;
    logic             in_beat;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic               ok_reg;
    logic [FIRST_W-1:0] first_reg;
    logic [COUNT_W-1:0] used_reg;
    logic [NUM_W-1:0]   fnum_reg;
    logic               rsp_take;

    // engine hookup
    eng_req_t           eng_req;
    eng_stat_t          eng_stat;
    logic [FIRST_W-1:0] eng_first;
    logic [COUNT_W-1:0] eng_count;
    logic [BS_W-1:0]    bs_eff;
    logic [CNT_W-1:0]   limit;

    // ---------------- APB ----------------
    // word decode on paddr[2]; byte-lane bits are ignored
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bs_reg  <= BS_RESET;
            biu_reg <= BIU_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[2])
                REG_BLOCK_SIZE:    bs_reg  <= pwdata[BS_W-1:0];
                REG_BLOCKS_IN_USE: biu_reg <= pwdata[BIU_W-1:0];
                default:           bs_reg  <= bs_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_BLOCK_SIZE:    prdata = PDATA_W'(bs_reg);
            REG_BLOCKS_IN_USE: prdata = PDATA_W'(biu_reg);
            default:           prdata = '0;
        endcase
    end

    // block size 0 acts as 1; blocks_in_use clamps at the map size
    always_comb
    begin
        bs_eff = (bs_reg == '0) ? BS_W'(1) : bs_reg;
        if (32'(biu_reg) > 32'(MAX_BLOCKS))
        begin
            limit = CNT_W'(MAX_BLOCKS);
        end
        else
        begin
            limit = CNT_W'(biu_reg);
        end
    end

    // ---------------- request side ----------------
    assign in_stall = !eng_stat.idle;
    assign in_beat  = in_valid && !in_stall;

    assign eng_req.start = in_beat;
    assign eng_req.clear = (cmd == CMD_CLEAR);

    // file number is the counter before the request; only allocates advance it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_cnt_reg <= '0;
        end
        else if (in_beat && (cmd == CMD_ALLOC))
        begin
            req_cnt_reg <= req_cnt_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            num_reg <= req_cnt_reg;
        end
    end

    cffa_engine #(
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_engine (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (eng_req),
        .size     (file_size_kb),
        .blk_size (bs_eff),
        .limit    (limit),
        .rsp_take (rsp_take),
        .stat     (eng_stat),
        .first    (eng_first),
        .count    (eng_count)
    );

    // ---------------- result side ----------------
    // engine hands over a result only when the output register is empty or not stalled
    assign rsp_take = !out_valid_reg || !out_stall;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (eng_stat.done)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (eng_stat.done)
        begin
            ok_reg    <= eng_stat.ok;
            first_reg <= eng_first;
            used_reg  <= eng_count;
            fnum_reg  <= num_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign ok          = ok_reg;
    assign first_block = first_reg;
    assign blocks_used = used_reg;
    assign file_number = fnum_reg;

endmodule

// ----- hw/rtl/cffa_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cffa_checker
// Port-level checks of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module cffa_checker
    import cffa_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic               ok,
    input logic [FIRST_W-1:0] first_block,
    input logic [COUNT_W-1:0] blocks_used,
    input logic [NUM_W-1:0]   file_number
);

    // a held result beat keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(ok) && $stable(first_block)
            && $stable(blocks_used) && $stable(file_number))
        else $error("result beat changed while stalled");

    // one request in flight: an accepted beat stalls the next
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("request accepted while previous one still in flight");

    // a failed allocation reports no run
    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> (first_block == '0) && (blocks_used == '0))
        else $error("failed allocation reported a block run");

    // a new result only appears from a busy engine
    a_rise_from_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall, 2))
        else $error("result produced without a request in flight");

endmodule

bind contiguous_first_fit_allocator_top cffa_checker u_cffa_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .ok          (ok),
    .first_block (first_block),
    .blocks_used (blocks_used),
    .file_number (file_number)
);
